// ===== src/jmsp_pkg.sv =====
`timescale 1ns / 1ps

package jmsp_pkg;

   localparam logic [1:0] KIND_SEGMENT    = 2'd0;
   localparam logic [1:0] KIND_NO_PREFIX  = 2'd1;
   localparam logic [1:0] KIND_BAD_LENGTH = 2'd2;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_STUFF  = 8'h00;
   localparam logic [7:0] MARK_RST_LO = 8'hD0;
   localparam logic [7:0] MARK_RST_HI = 8'hD7;

   localparam logic REG_SCAN_TO_TAIL = 1'b0;
   localparam logic REG_TOTAL_LENGTH = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DATA_W  = 72;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [31:0] offset;
      logic [31:0] length;
   } jmsp_result_type;

   typedef struct packed {
      logic            two;
      jmsp_result_type first;
      jmsp_result_type second;
   } jmsp_entry_type;

endpackage

// ===== src/jmsp_front.sv =====
`timescale 1ns / 1ps

module jmsp_front
   import jmsp_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   input  logic           csr_index,
   input  logic [31:0]    csr_data,
   input  logic           in_valid,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output logic           in_ready,
   input  logic           queue_full,
   output logic           push_valid,
   output jmsp_entry_type push_entry
);

   localparam int CW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;

   typedef enum logic [3:0] {
      PH_PREFIX, PH_CODE, PH_LENH, PH_LENL, PH_SKIP, PH_SCAN,
      PH_SCANFF, PH_TAILSKIP, PH_TAILA, PH_TAILB, PH_HALT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] seg_ff, seg_in;
   logic [7:0]             marker_ff, marker_in;
   logic [31:0]            skip_ff, skip_in;
   logic [7:0]             lenh_ff, lenh_in;
   logic                   end_ff, end_in;
   logic                   tail_mode_ff;
   logic [31:0]            total_ff;

   logic                   accept;
   logic [OFFSET_BITS-1:0] here, after, ff_pos, scan_len;
   logic [CW-1:0]          need, tot, tail_len;
   logic [31:0]            tail_len32;
   logic [15:0]            len16;

   logic                   tc_emit, tc_marker, tc_seg, tc_skip, tc_end;
   phase_type              tc_phase;
   jmsp_result_type        tc_res;

   logic                   have, two;
   jmsp_result_type        r0, r1;

   function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+31:0] ext;
      ext = {32'b0, v};
      return ext[31:0];
   endfunction

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;

   assign here       = pos_ff;
   assign after      = pos_ff + OFFSET_BITS'(1);
   assign ff_pos     = pos_ff - OFFSET_BITS'(1);
   assign scan_len   = ff_pos - seg_ff;
   assign need       = CW'(after) + CW'(2);
   assign tot        = CW'(total_ff);
   assign tail_len   = (tot >= need) ? (tot - need) : '0;
   assign tail_len32 = tail_len[31:0];
   assign len16      = {lenh_ff, in_byte};

   // marker code decode
   always_comb begin
      tc_emit   = 1'b0;
      tc_marker = 1'b0;
      tc_seg    = 1'b0;
      tc_skip   = 1'b0;
      tc_end    = 1'b0;
      tc_phase  = PH_LENH;
      tc_res    = '{kind: KIND_SEGMENT, code: in_byte, offset: to32(after), length: '0};
      priority if (in_byte == MARK_SOI) begin
         tc_emit  = 1'b1;
         tc_phase = PH_PREFIX;
      end else if (in_byte == MARK_EOI) begin
         tc_emit  = 1'b1;
         tc_end   = 1'b1;
         tc_phase = PH_PREFIX;
      end else if (in_byte == MARK_SOS && tail_mode_ff) begin
         tc_emit       = 1'b1;
         tc_skip       = 1'b1;
         tc_res.length = tail_len32;
         tc_phase      = (tail_len32 == '0) ? PH_TAILA : PH_TAILSKIP;
      end else if (in_byte == MARK_SOS ||
                   (in_byte >= MARK_RST_LO && in_byte <= MARK_RST_HI)) begin
         tc_marker = 1'b1;
         tc_seg    = 1'b1;
         tc_phase  = PH_SCAN;
      end else begin
         tc_marker = 1'b1;
         tc_phase  = PH_LENH;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      seg_in    = seg_ff;
      marker_in = marker_ff;
      skip_in   = skip_ff;
      lenh_in   = lenh_ff;
      end_in    = end_ff;
      pos_in    = after;
      have      = 1'b0;
      two       = 1'b0;
      r0        = '0;
      r1        = '0;
      unique case (phase_ff)
         PH_PREFIX: begin
            if (in_byte == MARK_PREFIX) begin
               phase_in = PH_CODE;
            end else begin
               have     = !end_ff;
               r0       = '{kind: KIND_NO_PREFIX, code: in_byte, offset: to32(here),
                            length: '0};
               phase_in = PH_HALT;
            end
         end
         PH_CODE: begin
            have     = tc_emit;
            r0       = tc_res;
            phase_in = tc_phase;
            if (tc_marker) marker_in = in_byte;
            if (tc_seg) seg_in = after;
            if (tc_skip) skip_in = tail_len32;
            if (tc_end) end_in = 1'b1;
         end
         PH_LENH: begin
            lenh_in  = in_byte;
            phase_in = PH_LENL;
         end
         PH_LENL: begin
            have = 1'b1;
            if (len16 < 16'd2) begin
               r0       = '{kind: KIND_BAD_LENGTH, code: marker_ff, offset: to32(after),
                            length: 32'(len16)};
               phase_in = PH_HALT;
            end else begin
               r0       = '{kind: KIND_SEGMENT, code: marker_ff, offset: to32(after),
                            length: 32'(len16 - 16'd2)};
               skip_in  = 32'(len16 - 16'd2);
               phase_in = (len16 == 16'd2) ? PH_PREFIX : PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) phase_in = PH_PREFIX;
         end
         PH_SCAN: begin
            if (in_byte == MARK_PREFIX) phase_in = PH_SCANFF;
         end
         PH_SCANFF: begin
            if (in_byte == MARK_STUFF) begin
               phase_in = PH_SCAN;
            end else begin
               have     = 1'b1;
               two      = tc_emit;
               r0       = '{kind: KIND_SEGMENT, code: marker_ff, offset: to32(seg_ff),
                            length: to32(scan_len)};
               r1       = tc_res;
               phase_in = tc_phase;
               if (tc_marker) marker_in = in_byte;
               if (tc_seg) seg_in = after;
               if (tc_skip) skip_in = tail_len32;
               if (tc_end) end_in = 1'b1;
            end
         end
         PH_TAILSKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) phase_in = PH_TAILA;
         end
         PH_TAILA: begin
            phase_in = PH_TAILB;
         end
         PH_TAILB: begin
            have     = 1'b1;
            r0       = '{kind: KIND_SEGMENT, code: in_byte, offset: to32(after),
                         length: '0};
            phase_in = PH_PREFIX;
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
      // last byte of a file returns the parse state to start
      if (in_last) begin
         phase_in  = PH_PREFIX;
         pos_in    = '0;
         seg_in    = '0;
         marker_in = '0;
         skip_in   = '0;
         lenh_in   = '0;
         end_in    = 1'b0;
      end
   end

   assign push_valid        = accept && have;
   assign push_entry.two    = two;
   assign push_entry.first  = r0;
   assign push_entry.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         pos_ff       <= '0;
         seg_ff       <= '0;
         marker_ff    <= '0;
         skip_ff      <= '0;
         lenh_ff      <= '0;
         end_ff       <= 1'b0;
         tail_mode_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_SCAN_TO_TAIL: tail_mode_ff <= csr_data[0];
               REG_TOTAL_LENGTH: total_ff     <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            seg_ff    <= seg_in;
            marker_ff <= marker_in;
            skip_ff   <= skip_in;
            lenh_ff   <= lenh_in;
            end_ff    <= end_in;
         end
      end
   end

endmodule

// ===== src/jmsp_queue.sv =====
`timescale 1ns / 1ps

module jmsp_queue
   import jmsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  jmsp_entry_type push_entry,
   output logic           full,
   output logic           head_valid,
   output jmsp_entry_type head_entry,
   input  logic           pop
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   jmsp_entry_type   slot_ff [QUEUE_DEPTH];
   jmsp_entry_type   slot_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in, wr_cnt;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[0];

   // shift queue: head always sits in slot zero
   always_comb begin
      slot_in = slot_ff;
      wr_cnt  = pop ? (cnt_ff - CNT_W'(1)) : cnt_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
      if (push_valid) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (wr_cnt == CNT_W'(i)) slot_in[i] = push_entry;
         end
      end
      cnt_in = wr_cnt + CNT_W'(push_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== src/jmsp_back.sv =====
`timescale 1ns / 1ps

module jmsp_back
   import jmsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  jmsp_entry_type        head_entry,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic            valid_ff;
   logic            half_ff;
   logic            last_ff;
   jmsp_result_type res_ff;
   logic            load;

   assign load = !valid_ff || rsp_tready;
   assign pop  = load && head_valid && (!head_entry.two || half_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
         if (head_valid) begin
            // two-result entries go out first half, then second
            if (head_entry.two && !half_ff) begin
               res_ff  <= head_entry.first;
               last_ff <= 1'b0;
               half_ff <= 1'b1;
            end else begin
               res_ff  <= head_entry.two ? head_entry.second : head_entry.first;
               last_ff <= 1'b1;
               half_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.length, res_ff.offset, res_ff.code};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = last_ff;

endmodule

// ===== src/jpeg_marker_segment_parser_top.sv =====
`timescale 1ns / 1ps

// JPEG marker segment parser. File bytes arrive one per req transaction (tlast on
// the final byte of a file); for each segment a descriptor leaves on rsp with the
// marker code, payload offset and payload length, or an error in tuser. One byte
// is accepted every clock cycle while the four-entry result queue has room; a byte
// that closes an entropy-coded scan and is itself reported at once (SOI, EOI, or
// SOS in tail mode) yields two results, which leave on rsp one after the other. Set
// scan_to_tail and total_length over csr only while no byte is in flight.
module jpeg_marker_segment_parser_top
   import jmsp_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // byte_value
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // marker_code, payload_offset, payload_length
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast
);

   logic           push_valid;
   jmsp_entry_type push_entry;
   logic           queue_full;
   logic           head_valid;
   jmsp_entry_type head_entry;
   logic           pop;

   assign csr_ready = 1'b1;

   jmsp_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   jmsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   jmsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/jmsp_checker.sv =====
`timescale 1ns / 1ps

module jmsp_checker
   import jmsp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined result kind");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_SEGMENT |-> rsp_tlast)
      else $error("error result not last of its byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind jpeg_marker_segment_parser_top jmsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
